// ===== rtl/core/tstc_pkg.sv =====
// Shared types and constants for the touch swipe/tap classifier.
// Used by every module of the block; no dependencies of its own.
package tstc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TAP_MAX_MS       = 3'd0,
      CSR_SWIPE_WINDOW_MS  = 3'd1,
      CSR_SWIPE_MIN_PX     = 3'd2,
      CSR_LEVEL_STEP       = 3'd3,
      CSR_BRIGHTNESS_FLOOR = 3'd4
   } csr_index_type;

   localparam logic [15:0] TAP_MAX_MS_RST       = 16'd500;
   localparam logic [15:0] SWIPE_WINDOW_MS_RST  = 16'd1000;
   localparam logic [11:0] SWIPE_MIN_PX_RST     = 12'd50;
   localparam logic [6:0]  LEVEL_STEP_RST       = 7'd10;
   localparam logic [6:0]  BRIGHTNESS_FLOOR_RST = 7'd10;

   localparam logic [6:0] LEVEL_MAX      = 7'd100;
   localparam logic [6:0] BRIGHTNESS_RST = 7'd100;

   typedef enum logic [2:0] {
      GEST_NONE       = 3'd0,
      GEST_TAP        = 3'd1,
      GEST_VOL_UP     = 3'd2,
      GEST_VOL_DOWN   = 3'd3,
      GEST_BRIGHT_UP  = 3'd4,
      GEST_BRIGHT_DN  = 3'd5
   } gesture_type;

   typedef struct packed {
      logic [15:0] tap_max_ms;
      logic [15:0] swipe_window_ms;
      logic [11:0] swipe_min_px;
      logic [6:0]  level_step;
      logic [6:0]  brightness_floor;
   } cfg_type;

   typedef struct packed {
      logic        pressed;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [31:0] now_ms;
      logic [6:0]  volume_in;
   } sample_type;

   typedef struct packed {
      gesture_type gesture;
      logic [6:0]  volume_out;
      logic [6:0]  brightness_out;
   } result_type;

endpackage

// ===== rtl/core/tstc_csr.sv =====
// Configuration registers of the classifier, written through a plain write port.
// Depends on tstc_pkg for the register indexes, reset values and cfg_type.
module tstc_csr
   import tstc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_MAX_MS:       cfg_in.tap_max_ms       = csr_wdata;
            CSR_SWIPE_WINDOW_MS:  cfg_in.swipe_window_ms  = csr_wdata;
            CSR_SWIPE_MIN_PX:     cfg_in.swipe_min_px     = csr_wdata[11:0];
            CSR_LEVEL_STEP:       cfg_in.level_step       = csr_wdata[6:0];
            CSR_BRIGHTNESS_FLOOR: cfg_in.brightness_floor = csr_wdata[6:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_max_ms       <= TAP_MAX_MS_RST;
         cfg_ff.swipe_window_ms  <= SWIPE_WINDOW_MS_RST;
         cfg_ff.swipe_min_px     <= SWIPE_MIN_PX_RST;
         cfg_ff.level_step       <= LEVEL_STEP_RST;
         cfg_ff.brightness_floor <= BRIGHTNESS_FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/tstc_engine.sv =====
// Touch state and the combinational classification of one sample.
// Depends on tstc_pkg; the state advances only when a sample moves on.
module tstc_engine
   import tstc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  sample_type sample,
   input  cfg_type    cfg,
   output result_type result
);

   logic        touch_active_ff, touch_active_in;
   logic [31:0] start_time_ff, start_time_in;
   logic [11:0] start_x_ff, start_x_in;
   logic [11:0] start_y_ff, start_y_in;
   logic        swipe_done_ff, swipe_done_in;
   logic [6:0]  bright_ff, bright_in;

   logic [31:0] elapsed;
   logic [11:0] adx, ady;
   logic [13:0] adx3, ady3;
   logic        h_move, v_move, in_window;
   logic [7:0]  vol_sum, bright_sum;
   logic [6:0]  vol_up, vol_dn, vol_diff;
   logic [6:0]  bright_up, bright_dn, bright_diff;

   always_comb begin
      elapsed = sample.now_ms - start_time_ff;
      adx = (sample.pos_x >= start_x_ff) ? sample.pos_x - start_x_ff
                                        : start_x_ff - sample.pos_x;
      ady = (sample.pos_y >= start_y_ff) ? sample.pos_y - start_y_ff
                                        : start_y_ff - sample.pos_y;
      // Three halves of a distance: (3 * d) / 2 rounded down.
      adx3 = {2'b00, adx} + {1'b0, adx, 1'b0};
      ady3 = {2'b00, ady} + {1'b0, ady, 1'b0};
      h_move = (adx > cfg.swipe_min_px) && ({1'b0, adx} > ady3[13:1]);
      v_move = (ady > cfg.swipe_min_px) && ({1'b0, ady} > adx3[13:1]);
      in_window = elapsed < {16'd0, cfg.swipe_window_ms};

      vol_sum  = {1'b0, sample.volume_in} + {1'b0, cfg.level_step};
      vol_up   = (vol_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : vol_sum[6:0];
      vol_diff = (sample.volume_in >= cfg.level_step) ?
                 sample.volume_in - cfg.level_step : 7'd0;
      vol_dn   = (vol_diff > LEVEL_MAX) ? LEVEL_MAX : vol_diff;

      bright_sum  = {1'b0, bright_ff} + {1'b0, cfg.level_step};
      bright_up   = (bright_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : bright_sum[6:0];
      bright_diff = (bright_ff >= cfg.level_step) ? bright_ff - cfg.level_step : 7'd0;
      if (bright_diff < cfg.brightness_floor) begin
         bright_diff = cfg.brightness_floor;
      end
      bright_dn = (bright_diff > LEVEL_MAX) ? LEVEL_MAX : bright_diff;
   end

   always_comb begin
      touch_active_in = touch_active_ff;
      start_time_in   = start_time_ff;
      start_x_in      = start_x_ff;
      start_y_in      = start_y_ff;
      swipe_done_in   = swipe_done_ff;
      bright_in       = bright_ff;
      result.gesture    = GEST_NONE;
      result.volume_out = sample.volume_in;

      priority if (sample.pressed && !touch_active_ff) begin
         touch_active_in = 1'b1;
         start_time_in   = sample.now_ms;
         start_x_in      = sample.pos_x;
         start_y_in      = sample.pos_y;
         swipe_done_in   = 1'b0;
      end else if (sample.pressed && !swipe_done_ff) begin
         if (in_window && h_move) begin
            swipe_done_in = 1'b1;
            if (sample.pos_x > start_x_ff) begin
               result.gesture    = GEST_VOL_UP;
               result.volume_out = vol_up;
            end else begin
               result.gesture    = GEST_VOL_DOWN;
               result.volume_out = vol_dn;
            end
         end else if (in_window && v_move) begin
            swipe_done_in = 1'b1;
            // Smaller y is further up the screen.
            if (sample.pos_y < start_y_ff) begin
               result.gesture = GEST_BRIGHT_UP;
               bright_in      = bright_up;
            end else begin
               result.gesture = GEST_BRIGHT_DN;
               bright_in      = bright_dn;
            end
         end
      end else if (!sample.pressed && touch_active_ff) begin
         touch_active_in = 1'b0;
         swipe_done_in   = 1'b0;
         if (!swipe_done_ff && (elapsed < {16'd0, cfg.tap_max_ms})) begin
            result.gesture = GEST_TAP;
         end
      end else begin
         touch_active_in = touch_active_ff;
      end

      result.brightness_out = bright_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_active_ff <= 1'b0;
         start_time_ff   <= 32'd0;
         start_x_ff      <= 12'd0;
         start_y_ff      <= 12'd0;
         swipe_done_ff   <= 1'b0;
         bright_ff       <= BRIGHTNESS_RST;
      end else if (advance) begin
         touch_active_ff <= touch_active_in;
         start_time_ff   <= start_time_in;
         start_x_ff      <= start_x_in;
         start_y_ff      <= start_y_in;
         swipe_done_ff   <= swipe_done_in;
         bright_ff       <= bright_in;
      end
   end

`ifndef ASSERT_OFF
   a_swipe_needs_touch: assert property (@(posedge clock) disable iff (reset)
      swipe_done_ff |-> touch_active_ff)
      else $error("swipe marked without an active touch");

   a_bright_in_range: assert property (@(posedge clock) disable iff (reset)
      bright_ff <= LEVEL_MAX)
      else $error("brightness level above maximum");

   a_tap_ends_touch: assert property (@(posedge clock) disable iff (reset)
      (advance && result.gesture == GEST_TAP) |=> !touch_active_ff && !swipe_done_ff)
      else $error("touch still active after a tap");

   a_swipe_sets_done: assert property (@(posedge clock) disable iff (reset)
      (advance && (result.gesture == GEST_VOL_UP || result.gesture == GEST_VOL_DOWN ||
                   result.gesture == GEST_BRIGHT_UP || result.gesture == GEST_BRIGHT_DN))
      |=> swipe_done_ff)
      else $error("swipe gesture reported without marking the touch");
`endif

endmodule

// ===== rtl/core/touch_swipe_tap_classifier_top.sv =====
// Touch swipe/tap classifier, top level.
// Data path: a sample accepted into the input register is classified into the result
// register, which drives rsp_*.
// Throughput: one sample per cycle; a held result stalls the input only when both stages are full.
// Reset: synchronous, active high; clears the pipeline, touch state, brightness to 100
// and the configuration registers to their defaults.
module touch_swipe_tap_classifier_top
   import tstc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_pressed,
   input  logic [11:0]            req_pos_x,
   input  logic [11:0]            req_pos_y,
   input  logic [31:0]            req_now_ms,
   input  logic [6:0]             req_volume_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_gesture,
   output logic [6:0]             rsp_volume_out,
   output logic [6:0]             rsp_brightness_out
);

   cfg_type    cfg;
   sample_type in_word_ff;
   logic       in_valid_ff;
   result_type engine_result;
   result_type out_word_ff;
   logic       out_valid_ff;
   logic       out_free;
   logic       advance;
   logic       req_take;

   tstc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tstc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_word_ff),
      .cfg     (cfg),
      .result  (engine_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.pressed   <= req_pressed;
         in_word_ff.pos_x     <= req_pos_x;
         in_word_ff.pos_y     <= req_pos_y;
         in_word_ff.now_ms    <= req_now_ms;
         in_word_ff.volume_in <= req_volume_in;
      end
      if (advance) begin
         out_word_ff <= engine_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_gesture        = out_word_ff.gesture;
   assign rsp_volume_out     = out_word_ff.volume_out;
   assign rsp_brightness_out = out_word_ff.brightness_out;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_word_ff))
      else $error("waiting input word lost or changed");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after a word moved in");

   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (rsp_gesture <= 3'd5))
      else $error("result word carries an unknown gesture code");
`endif

endmodule
